>>> hdl/ebwv_pkg.sv
package ebwv_pkg;

  // Depth of the job queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // The header is three address bytes followed by two length bytes.
  localparam int HDR_BYTES = 5;
  localparam int HIDX_W    = $clog2(HDR_BYTES);

  localparam logic [7:0] CMD_PROGRAM = 8'h84;
  localparam logic [7:0] BYTE_ACK    = 8'hAA;
  localparam logic [7:0] BYTE_TERM   = 8'hEA;
  localparam logic [7:0] CMD_VERIFY  = 8'h33;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_DATA  = 2'd1,
    ACT_RX    = 2'd2,
    ACT_FAULT = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ACK   = 3'd1,
    ST_BAD_TERM  = 3'd2,
    ST_BAD_VACK  = 3'd3,
    ST_BAD_VTERM = 3'd4,
    ST_MISMATCH  = 3'd5,
    ST_FAULT     = 3'd6
  } status_t;

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_WAIT_ACK  = 7'b0000010,
    PH_PAYLOAD   = 7'b0000100,
    PH_WAIT_TERM = 7'b0001000,
    PH_WAIT_VACK = 7'b0010000,
    PH_WAIT_CHK  = 7'b0100000,
    PH_WAIT_VTRM = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    JOB_TX  = 2'd0,
    JOB_HDR = 2'd1,
    JOB_FIN = 2'd2
  } job_kind_t;

  // One unit of work for the back part: a single byte, a header burst or an end status.
  typedef struct packed {
    job_kind_t    kind;
    logic [7:0]   tx_byte;
    status_t      status;
    logic [23:0]  addr;
    logic [15:0]  len;
  } job_t;

endpackage

>>> hdl/eeprom_block_write_verify_exchange.sv
// Master side of a byte-serial block program-and-verify exchange. Each input item is a start
// request, a payload byte to send, a byte received from the partner or a link fault; each
// result item is either a byte to transmit or an end-of-exchange status, and the final result
// caused by an item carries out_last. The block takes one item per clock cycle while its job
// queue has room. A start, a payload byte, the data terminator and every error or end status
// give one result each; the partner's acknowledge of the command gives five (three address
// bytes and two length bytes, least significant first), emitted at one per cycle while
// out_ready is high. The output rate is therefore one result per cycle while out_ready is
// high; a burst of header acknowledges is buffered in a four-entry queue, so the input stalls
// only when the queue is full. Jobs are queued and then loaded into the output register. Items
// that do not fit the current phase of the exchange are absorbed without any result.
module eeprom_block_write_verify_exchange (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [23:0] in_address,
  input  logic [15:0] in_length,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_done_res,
  output logic [2:0]  out_status,
  output logic        out_last
);
  import ebwv_pkg::*;

  logic in_accept;
  logic q_push;
  job_t q_push_job;
  logic q_pop;
  logic q_valid;
  job_t q_head;
  logic q_full;

  // An item is taken whenever the queue can hold whatever job it might produce.
  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  // The front part tracks the exchange phase, the latched header and the running XOR,
  // and turns each accepted item into at most one job.
  ebwv_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .action     (in_action),
    .address    (in_address),
    .length     (in_length),
    .byte_value (in_byte_value),
    .push       (q_push),
    .job        (q_push_job)
  );

  // The queue decouples the front part from the output back-pressure.
  ebwv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_head),
    .full       (q_full)
  );

  // The back part expands each job into result items and holds them in the output register.
  ebwv_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (q_valid),
    .head_job     (q_head),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_tx_valid (out_tx_valid),
    .out_tx_byte  (out_tx_byte),
    .out_done_res (out_done_res),
    .out_status   (out_status),
    .out_last     (out_last)
  );

`ifndef SYNTHESIS
  // The back part must never retire a job that is not there.
  a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("job queue popped while empty");

  // A job is only produced for an accepted item, and the queue had room for it.
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (in_accept && !q_full))
    else $error("job pushed without an accepted item or into a full queue");

  // An end-of-exchange result is always the final result of its item and carries no byte.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> (out_last && !out_tx_valid))
    else $error("status result not marked last or carrying a byte");
`endif

endmodule

>>> hdl/ebwv_front.sv
module ebwv_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [1:0]          action,
  input  logic [23:0]         address,
  input  logic [15:0]         length,
  input  logic [7:0]          byte_value,
  output logic                push,
  output ebwv_pkg::job_t      job
);
  import ebwv_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [23:0] addr_r, addr_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [7:0]  chk_r, chk_nxt;
  action_t     act;

  assign act = action_t'(action);

  always_comb begin
    phase_nxt = phase_r;
    addr_nxt  = addr_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    xor_nxt   = xor_r;
    chk_nxt   = chk_r;
    push      = 1'b0;
    job.kind    = JOB_TX;
    job.tx_byte = '0;
    job.status  = ST_OK;
    job.addr    = addr_r;
    job.len     = len_r;
    if (accept) begin
      unique case (act)
        ACT_FAULT: begin
          if (phase_r != PH_IDLE) begin
            push       = 1'b1;
            job.kind   = JOB_FIN;
            job.status = ST_FAULT;
            phase_nxt  = PH_IDLE;
          end
        end
        ACT_START: begin
          if (phase_r == PH_IDLE) begin
            addr_nxt    = address;
            len_nxt     = length;
            rem_nxt     = length;
            xor_nxt     = '0;
            chk_nxt     = '0;
            phase_nxt   = PH_WAIT_ACK;
            push        = 1'b1;
            job.tx_byte = CMD_PROGRAM;
          end
        end
        ACT_DATA: begin
          if (phase_r == PH_PAYLOAD) begin
            xor_nxt     = xor_r ^ byte_value;
            rem_nxt     = rem_r - 16'd1;
            push        = 1'b1;
            job.tx_byte = byte_value;
            if (rem_r == 16'd1) begin
              phase_nxt = PH_WAIT_TERM;
            end
          end
        end
        ACT_RX: begin
          unique case (phase_r)
            PH_WAIT_ACK: begin
              push = 1'b1;
              if (byte_value != BYTE_ACK) begin
                job.kind   = JOB_FIN;
                job.status = ST_BAD_ACK;
                phase_nxt  = PH_IDLE;
              end else begin
                job.kind = JOB_HDR;
                if (len_r == 16'd0) begin
                  phase_nxt = PH_WAIT_TERM;
                end else begin
                  phase_nxt = PH_PAYLOAD;
                end
              end
            end
            PH_WAIT_TERM: begin
              push = 1'b1;
              if (byte_value != BYTE_TERM) begin
                job.kind   = JOB_FIN;
                job.status = ST_BAD_TERM;
                phase_nxt  = PH_IDLE;
              end else begin
                job.tx_byte = CMD_VERIFY;
                phase_nxt   = PH_WAIT_VACK;
              end
            end
            PH_WAIT_VACK: begin
              if (byte_value != BYTE_ACK) begin
                push       = 1'b1;
                job.kind   = JOB_FIN;
                job.status = ST_BAD_VACK;
                phase_nxt  = PH_IDLE;
              end else begin
                phase_nxt = PH_WAIT_CHK;
              end
            end
            PH_WAIT_CHK: begin
              chk_nxt   = byte_value;
              phase_nxt = PH_WAIT_VTRM;
            end
            PH_WAIT_VTRM: begin
              push      = 1'b1;
              job.kind  = JOB_FIN;
              phase_nxt = PH_IDLE;
              if (byte_value != BYTE_TERM) begin
                job.status = ST_BAD_VTERM;
              end else if ((chk_r ^ xor_r) != 8'd0) begin
                job.status = ST_MISMATCH;
              end else begin
                job.status = ST_OK;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    len_r  <= len_nxt;
    rem_r  <= rem_nxt;
    xor_r  <= xor_nxt;
    chk_r  <= chk_nxt;
  end

endmodule

>>> hdl/ebwv_queue.sv
module ebwv_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ebwv_pkg::job_t      push_job,
  input  logic                pop,
  output logic                head_valid,
  output ebwv_pkg::job_t      head_job,
  output logic                full
);
  import ebwv_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> hdl/ebwv_back.sv
module ebwv_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  ebwv_pkg::job_t      head_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_tx_valid,
  output logic [7:0]          out_tx_byte,
  output logic                out_done_res,
  output logic [2:0]          out_status,
  output logic                out_last
);
  import ebwv_pkg::*;

  logic              load;
  logic [HIDX_W-1:0] idx_r, idx_nxt;
  logic              valid_r, valid_nxt;
  logic              tx_valid_r, tx_valid_nxt;
  logic [7:0]        tx_byte_r, tx_byte_nxt;
  logic              done_r, done_nxt;
  status_t           status_r, status_nxt;
  logic              last_r, last_nxt;
  logic              hdr_end;

  assign load    = head_valid && (!valid_r || out_ready);
  assign hdr_end = (idx_r == HIDX_W'(HDR_BYTES - 1));

  always_comb begin
    pop          = 1'b0;
    idx_nxt      = idx_r;
    tx_valid_nxt = 1'b0;
    tx_byte_nxt  = '0;
    done_nxt     = 1'b0;
    status_nxt   = ST_OK;
    last_nxt     = 1'b1;
    unique case (head_job.kind)
      JOB_TX: begin
        tx_valid_nxt = 1'b1;
        tx_byte_nxt  = head_job.tx_byte;
        pop          = load;
      end
      JOB_HDR: begin
        tx_valid_nxt = 1'b1;
        last_nxt     = hdr_end;
        case (idx_r)
          HIDX_W'(0): tx_byte_nxt = head_job.addr[7:0];
          HIDX_W'(1): tx_byte_nxt = head_job.addr[15:8];
          HIDX_W'(2): tx_byte_nxt = head_job.addr[23:16];
          HIDX_W'(3): tx_byte_nxt = head_job.len[7:0];
          default:    tx_byte_nxt = head_job.len[15:8];
        endcase
        if (load) begin
          if (hdr_end) begin
            pop     = 1'b1;
            idx_nxt = '0;
          end else begin
            idx_nxt = idx_r + HIDX_W'(1);
          end
        end
      end
      JOB_FIN: begin
        done_nxt   = 1'b1;
        status_nxt = head_job.status;
        pop        = load;
      end
      default: begin
        pop = load;
      end
    endcase
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx_valid_r <= tx_valid_nxt;
      tx_byte_r  <= tx_byte_nxt;
      done_r     <= done_nxt;
      status_r   <= status_nxt;
      last_r     <= last_nxt;
    end
  end

  assign out_valid    = valid_r;
  assign out_tx_valid = tx_valid_r;
  assign out_tx_byte  = tx_byte_r;
  assign out_done_res = done_r;
  assign out_status   = status_r;
  assign out_last     = last_r;

endmodule

>>> sim/ebwv_exchange_checker.sv
`timescale 1ns / 100ps

module ebwv_exchange_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [23:0] in_address,
  input  logic [15:0] in_length,
  input  logic [7:0]  in_byte_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_tx_valid,
  input  logic [7:0]  out_tx_byte,
  input  logic        out_done_res,
  input  logic [2:0]  out_status,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_results,
  output int          results_checked,
  output int          exchanges_closed
);
  import ebwv_pkg::*;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       done_res;
    status_t    status;
    logic       last;
  } exch_result_t;

  exch_result_t awaited_results[$];

  // Own copy of the exchange state, updated once per accepted item.
  phase_t      phase;
  logic [23:0] hdr_address;
  logic [15:0] hdr_length;
  logic [15:0] bytes_left;
  logic [7:0]  payload_xor;
  logic [7:0]  check_value;

  function automatic exch_result_t tx_result(logic [7:0] b, logic fin);
    exch_result_t r;
    r.tx_valid = 1'b1;
    r.tx_byte  = b;
    r.done_res = 1'b0;
    r.status   = ST_OK;
    r.last     = fin;
    return r;
  endfunction

  task automatic close_exchange(status_t st);
    exch_result_t r;
    r.tx_valid = 1'b0;
    r.tx_byte  = 8'h00;
    r.done_res = 1'b1;
    r.status   = st;
    r.last     = 1'b1;
    awaited_results.push_back(r);
    phase = PH_IDLE;
    exchanges_closed++;
  endtask

  task automatic predict_exchange_step(action_t act, logic [23:0] addr, logic [15:0] len,
                                       logic [7:0] b);
    case (act)
      ACT_FAULT: begin
        if (phase != PH_IDLE) close_exchange(ST_FAULT);
      end
      ACT_START: begin
        if (phase == PH_IDLE) begin
          hdr_address = addr;
          hdr_length  = len;
          bytes_left  = len;
          payload_xor = 8'h00;
          check_value = 8'h00;
          phase       = PH_WAIT_ACK;
          awaited_results.push_back(tx_result(CMD_PROGRAM, 1'b1));
        end
      end
      ACT_DATA: begin
        if (phase == PH_PAYLOAD) begin
          payload_xor = payload_xor ^ b;
          bytes_left  = bytes_left - 16'd1;
          if (bytes_left == 16'd0) phase = PH_WAIT_TERM;
          awaited_results.push_back(tx_result(b, 1'b1));
        end
      end
      default: begin
        case (phase)
          PH_WAIT_ACK: begin
            if (b != BYTE_ACK) begin
              close_exchange(ST_BAD_ACK);
            end else begin
              awaited_results.push_back(tx_result(hdr_address[7:0], 1'b0));
              awaited_results.push_back(tx_result(hdr_address[15:8], 1'b0));
              awaited_results.push_back(tx_result(hdr_address[23:16], 1'b0));
              awaited_results.push_back(tx_result(hdr_length[7:0], 1'b0));
              awaited_results.push_back(tx_result(hdr_length[15:8], 1'b1));
              phase = (hdr_length == 16'd0) ? PH_WAIT_TERM : PH_PAYLOAD;
            end
          end
          PH_WAIT_TERM: begin
            if (b != BYTE_TERM) begin
              close_exchange(ST_BAD_TERM);
            end else begin
              phase = PH_WAIT_VACK;
              awaited_results.push_back(tx_result(CMD_VERIFY, 1'b1));
            end
          end
          PH_WAIT_VACK: begin
            if (b != BYTE_ACK) close_exchange(ST_BAD_VACK);
            else phase = PH_WAIT_CHK;
          end
          PH_WAIT_CHK: begin
            check_value = b;
            phase       = PH_WAIT_VTRM;
          end
          PH_WAIT_VTRM: begin
            // The terminator is judged before the checksum.
            if (b != BYTE_TERM) close_exchange(ST_BAD_VTERM);
            else close_exchange(((check_value ^ payload_xor) == 8'h00) ? ST_OK : ST_MISMATCH);
          end
          default: begin
          end
        endcase
      end
    endcase
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    exch_result_t want;
    if (!rst_n) begin
      phase       = PH_IDLE;
      hdr_address = '0;
      hdr_length  = '0;
      bytes_left  = '0;
      payload_xor = '0;
      check_value = '0;
      awaited_results.delete();
    end else begin
      if (in_valid && in_ready)
        predict_exchange_step(action_t'(in_action), in_address, in_length, in_byte_value);
      if (out_valid && out_ready) begin
        results_checked++;
        if (awaited_results.size() == 0) begin
          $error("Unexpected result: tx_valid=%0b tx_byte=0x%0h done_res=%0b status=%0d",
                 out_tx_valid, out_tx_byte, out_done_res, out_status);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("tx_valid", 32'(want.tx_valid), 32'(out_tx_valid));
          check_field("tx_byte", 32'(want.tx_byte), 32'(out_tx_byte));
          check_field("done_res", 32'(want.done_res), 32'(out_done_res));
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("last", 32'(want.last), 32'(out_last));
        end
      end
    end
    pending_results = awaited_results.size();
  end

endmodule

>>> sim/eeprom_block_write_verify_exchange_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the block program-and-verify exchange master. All prediction and
// comparison lives in the checker instantiated beside the block; this module only produces
// items, throttles both channels and decides the outcome of the run.
module eeprom_block_write_verify_exchange_tb;
  import ebwv_pkg::*;

  localparam int TOTAL_ITEMS = 370;
  localparam int CYCLE_LIMIT = 200000;
  // Longest payload that is actually sent in full; longer exchanges are cut short by a fault.
  localparam int PAYLOAD_CAP = 12;
  localparam int NOISE_PCT   = 12;
  localparam int TAIL_CYCLES = 10;

  // Where a stray item is being slipped in, so that it is one the block must ignore.
  typedef enum {NS_IDLE, NS_BUSY, NS_PAYLOAD} noise_spot_t;
  // The point of an exchange at which a link fault is raised.
  typedef enum {SG_ACK, SG_PAYLOAD, SG_TERM, SG_VACK, SG_CHK, SG_VTRM} stage_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = ACT_START;
  logic [23:0] in_address = '0;
  logic [15:0] in_length = '0;
  logic [7:0]  in_byte_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_tx_valid;
  logic [7:0]  out_tx_byte;
  logic        out_done_res;
  logic [2:0]  out_status;
  logic        out_last;

  int fail_count;
  int pending_results;
  int results_checked;
  int exchanges_closed;
  int items_sent = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;

  eeprom_block_write_verify_exchange u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_address    (in_address),
    .in_length     (in_length),
    .in_byte_value (in_byte_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_tx_valid  (out_tx_valid),
    .out_tx_byte   (out_tx_byte),
    .out_done_res  (out_done_res),
    .out_status    (out_status),
    .out_last      (out_last)
  );

  ebwv_exchange_checker u_exchange_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_address       (in_address),
    .in_length        (in_length),
    .in_byte_value    (in_byte_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tx_valid     (out_tx_valid),
    .out_tx_byte      (out_tx_byte),
    .out_done_res     (out_done_res),
    .out_status       (out_status),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .pending_results  (pending_results),
    .results_checked  (results_checked),
    .exchanges_closed (exchanges_closed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a correct run finishes far inside this many cycles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results);
      $display("Some tests failed");
      $finish;
    end
  end

  // The result side is throttled independently of the sender, one decision per cycle.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Presents one item at a falling edge, after an optional random gap, and holds it until the
  // block takes it. Valid is left high on return so that a following item can go straight on
  // without valid dropping in between.
  task automatic send_item(action_t act, logic [23:0] addr, logic [15:0] len, logic [7:0] b);
    @(negedge clk);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_address    <= addr;
    in_length     <= len;
    in_byte_value <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Partner replies and payload bytes carry random values in the fields they do not use.
  task automatic send_rx(logic [7:0] b);
    send_item(ACT_RX, 24'($urandom), 16'($urandom), b);
  endtask

  task automatic send_data(logic [7:0] b);
    send_item(ACT_DATA, 24'($urandom), 16'($urandom), b);
  endtask

  task automatic send_fault();
    send_item(ACT_FAULT, 24'($urandom), 16'($urandom), 8'($urandom));
  endtask

  function automatic logic [7:0] byte_other_than(logic [7:0] avoid);
    logic [7:0] v;
    v = 8'($urandom);
    if (v == avoid) v = ~avoid;
    return v;
  endfunction

  // Now and then slips in an item that the current phase must ignore. In the payload phase a
  // partner byte or a second start is harmless; elsewhere in an exchange a payload byte or a
  // start is; in idle anything but a start is.
  task automatic maybe_noise(noise_spot_t spot);
    logic [7:0] b;
    int pick;
    b    = ($urandom_range(3) == 0) ? (($urandom_range(1) == 0) ? BYTE_ACK : BYTE_TERM)
                                    : 8'($urandom);
    pick = $urandom_range(2);
    if ($urandom_range(99) < NOISE_PCT) begin
      case (spot)
        NS_IDLE: begin
          if (pick == 0) send_fault();
          else if (pick == 1) send_data(b);
          else send_rx(b);
        end
        NS_BUSY: begin
          if (pick == 0) send_item(ACT_START, 24'($urandom), 16'($urandom), b);
          else send_data(b);
        end
        default: begin
          if (pick == 0) send_item(ACT_START, 24'($urandom), 16'($urandom), b);
          else send_rx(b);
        end
      endcase
    end
  endtask

  // One complete exchange steered towards the given outcome: a clean pass, one of the wrong
  // replies, a checksum mismatch, or a link fault at a randomly chosen point.
  task automatic run_exchange(status_t outcome);
    logic [23:0] addr;
    logic [15:0] len;
    logic [7:0]  payload_xor;
    logic [7:0]  b;
    stage_t      fault_at;
    int          r;
    int          n_bytes;
    r           = $urandom_range(99);
    addr        = 24'($urandom);
    payload_xor = 8'h00;
    if (r < 70) len = 16'($urandom_range(6));
    else if (r < 90) len = 16'($urandom_range(PAYLOAD_CAP, 7));
    else len = 16'($urandom);

    // Lengths beyond what is worth sending are always abandoned part-way with a fault.
    if (len > PAYLOAD_CAP) outcome = ST_FAULT;
    if (len > PAYLOAD_CAP) fault_at = SG_PAYLOAD;
    else fault_at = stage_t'($urandom_range(SG_VTRM, SG_ACK));
    if (fault_at == SG_PAYLOAD && len == 0) fault_at = SG_TERM;

    send_item(ACT_START, addr, len, 8'($urandom));
    maybe_noise(NS_BUSY);
    if (outcome == ST_FAULT && fault_at == SG_ACK) begin
      send_fault();
      return;
    end
    if (outcome == ST_BAD_ACK) begin
      send_rx(byte_other_than(BYTE_ACK));
      return;
    end
    send_rx(BYTE_ACK);

    if (len != 0) begin
      n_bytes = (outcome == ST_FAULT && fault_at == SG_PAYLOAD)
                ? $urandom_range((len > PAYLOAD_CAP) ? PAYLOAD_CAP : len - 1) : len;
      for (int i = 0; i < n_bytes; i++) begin
        maybe_noise(NS_PAYLOAD);
        b           = 8'($urandom);
        payload_xor = payload_xor ^ b;
        send_data(b);
      end
      if (outcome == ST_FAULT && fault_at == SG_PAYLOAD) begin
        send_fault();
        return;
      end
    end

    maybe_noise(NS_BUSY);
    if (outcome == ST_FAULT && fault_at == SG_TERM) begin
      send_fault();
      return;
    end
    if (outcome == ST_BAD_TERM) begin
      send_rx(byte_other_than(BYTE_TERM));
      return;
    end
    send_rx(BYTE_TERM);

    maybe_noise(NS_BUSY);
    if (outcome == ST_FAULT && fault_at == SG_VACK) begin
      send_fault();
      return;
    end
    if (outcome == ST_BAD_VACK) begin
      send_rx(byte_other_than(BYTE_ACK));
      return;
    end
    send_rx(BYTE_ACK);

    maybe_noise(NS_BUSY);
    if (outcome == ST_FAULT && fault_at == SG_CHK) begin
      send_fault();
      return;
    end
    // The check byte is taken whatever its value; only a mismatch case corrupts it.
    if (outcome == ST_MISMATCH) send_rx(payload_xor ^ byte_other_than(8'h00));
    else send_rx(payload_xor);

    maybe_noise(NS_BUSY);
    if (outcome == ST_FAULT && fault_at == SG_VTRM) begin
      send_fault();
      return;
    end
    if (outcome == ST_BAD_VTERM) send_rx(byte_other_than(BYTE_TERM));
    else send_rx(BYTE_TERM);
  endtask

  initial begin
    int sender_plan[4];
    int recv_plan[4];
    status_t outcome;
    sender_plan = '{0, 55, 0, 8};
    recv_plan   = '{0, 0, 55, 8};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, run without any throttling. Items in idle are ignored, including a
    // fault, a payload byte and a partner byte.
    send_fault();
    send_data(8'hFF);
    send_rx(BYTE_ACK);

    // All-ones address and length, a start while busy, partner noise during the payload and
    // a fault that cuts the long transfer short.
    send_item(ACT_START, 24'hFFFFFF, 16'hFFFF, 8'h00);
    send_item(ACT_START, 24'h000000, 16'h0000, 8'hFF);
    send_rx(BYTE_ACK);
    send_data(8'hFF);
    send_data(8'h00);
    send_rx(8'h55);
    send_fault();

    // Zero length goes straight to the terminator; a stray payload byte there is ignored.
    send_item(ACT_START, 24'h000000, 16'h0000, 8'hFF);
    send_rx(BYTE_ACK);
    send_data(8'h5A);
    send_rx(BYTE_TERM);
    send_rx(BYTE_ACK);
    send_rx(8'h00);
    send_rx(BYTE_TERM);

    // A wrong acknowledge to the command.
    send_item(ACT_START, 24'h123456, 16'h0001, 8'h00);
    send_rx(8'h00);

    // A wrong verify terminator together with a bad check byte: the terminator wins.
    send_item(ACT_START, 24'hA5A5A5, 16'h0000, 8'h00);
    send_rx(BYTE_ACK);
    send_rx(BYTE_TERM);
    send_rx(BYTE_ACK);
    send_rx(8'h77);
    send_rx(8'h00);

    // Random part in four throttling phases: none, sender gaps, receiver stalls, both light.
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = sender_plan[ph];
      recv_stall_pct  = recv_plan[ph];
      while (items_sent < (ph + 1) * TOTAL_ITEMS / 4) begin
        maybe_noise(NS_IDLE);
        if ($urandom_range(99) < 55) outcome = ST_OK;
        else outcome = status_t'($urandom_range(ST_FAULT, ST_BAD_ACK));
        run_exchange(outcome);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    // Ignored items leave nothing to wait for, so give the pipeline time to show strays.
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d items over four throttling phases; checked %0d results.",
             items_sent, results_checked);
    $display("Exchanges closed with a status: %0d.", exchanges_closed);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> eeprom_block_write_verify_exchange.f
hdl/ebwv_pkg.sv
hdl/ebwv_front.sv
hdl/ebwv_queue.sv
hdl/ebwv_back.sv
hdl/eeprom_block_write_verify_exchange.sv
sim/ebwv_exchange_checker.sv
sim/eeprom_block_write_verify_exchange_tb.sv
